// File: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, control word type and microcode ROM for the radix digit
// converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int NUMBER_WIDTH = 32;   // req_tdata payload width
   localparam int DIGIT_WIDTH  = 8;
   localparam int RADIX_WIDTH  = 9;
   localparam int VALUE_WIDTH  = 32;
   localparam int STACK_DEPTH  = 32;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 9'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 9'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 9'd256;

   // sequencer step addresses
   localparam int PC_WIDTH = 3;
   localparam logic [PC_WIDTH-1:0] PC_IDLE     = 3'd0;
   localparam logic [PC_WIDTH-1:0] PC_DIV_INIT = 3'd1;
   localparam logic [PC_WIDTH-1:0] PC_DIV_STEP = 3'd2;
   localparam logic [PC_WIDTH-1:0] PC_PUSH     = 3'd3;
   localparam logic [PC_WIDTH-1:0] PC_POP      = 3'd4;
   localparam logic [PC_WIDTH-1:0] PC_EMIT     = 3'd5;
   localparam logic [PC_WIDTH-1:0] PC_NEXT     = 3'd6;
   localparam logic [PC_WIDTH-1:0] PC_DONE     = 3'd7;

   // jump conditions
   localparam logic [2:0] COND_NEVER    = 3'd0;
   localparam logic [2:0] COND_ALWAYS   = 3'd1;
   localparam logic [2:0] COND_NO_REQ   = 3'd2;
   localparam logic [2:0] COND_BIT_LEFT = 3'd3;
   localparam logic [2:0] COND_QUOT_NZ  = 3'd4;
   localparam logic [2:0] COND_OUT_BUSY = 3'd5;
   localparam logic [2:0] COND_COUNT_NZ = 3'd6;

   typedef struct packed {
      logic                accept;
      logic                div_init;
      logic                div_step;
      logic                push;
      logic                pop;
      logic                emit;
      logic [2:0]          cond;
      logic [PC_WIDTH-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type cw;
      cw = '0;
      unique case (pc)
         PC_IDLE: begin
            cw.accept = 1'b1;
            cw.cond   = COND_NO_REQ;
            cw.target = PC_IDLE;
         end
         PC_DIV_INIT: begin
            cw.div_init = 1'b1;
            cw.cond     = COND_NEVER;
            cw.target   = PC_IDLE;
         end
         PC_DIV_STEP: begin
            cw.div_step = 1'b1;
            cw.cond     = COND_BIT_LEFT;
            cw.target   = PC_DIV_STEP;
         end
         PC_PUSH: begin
            cw.push   = 1'b1;
            cw.cond   = COND_QUOT_NZ;
            cw.target = PC_DIV_INIT;
         end
         PC_POP: begin
            cw.pop    = 1'b1;
            cw.cond   = COND_NEVER;
            cw.target = PC_IDLE;
         end
         PC_EMIT: begin
            cw.emit   = 1'b1;
            cw.cond   = COND_OUT_BUSY;
            cw.target = PC_EMIT;
         end
         PC_NEXT: begin
            cw.cond   = COND_COUNT_NZ;
            cw.target = PC_POP;
         end
         PC_DONE: begin
            cw.cond   = COND_ALWAYS;
            cw.target = PC_IDLE;
         end
         default: begin
            cw.cond   = COND_ALWAYS;
            cw.target = PC_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: hw/rtl/rdc_ram.sv
// ----------------------------------------------------------------------------
// rdc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an unsigned integer into base-radix digits, most significant first.
// ----------------------------------------------------------------------------
// Steps: every digit is divided out and pushed before the first is sent. Division
// per digit is init, one quotient bit per cycle and push; each digit out is pop,
// emit and a count check. Throughput: one transaction at a time; output stalls
// hold the sequencer.
// Reset: synchronous, active high; radix returns to 10, sequencer to idle.
module radix_digit_converter_core #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH,
   parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,  // radix
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] number_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] digit_out
   output logic        rsp_tlast     // last_digit
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int BW = $clog2(VALUE_WIDTH);
   localparam int DW = rdc_pkg::DIGIT_WIDTH;
   localparam int RW = rdc_pkg::RADIX_WIDTH;

   rdc_pkg::ucode_type cw;

   logic [rdc_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   logic [RW-1:0]          radix_ff, radix_in;
   logic [RW-1:0]          base_ff, base_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [BW-1:0]          bitcnt_ff, bitcnt_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]          rsp_digit_ff, rsp_digit_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   out_free;
   logic                   do_emit;
   logic                   jump;
   logic [RW-1:0]          trial;
   logic                   trial_ge;
   logic [63:0]            number_ext;
   logic [CW-1:0]          count_m1;
   logic                   stack_room;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [DW-1:0]          ram_rd_data;

   assign cw         = rdc_pkg::ucode_rom(pc_ff);
   assign req_tready = cw.accept;
   assign accept     = req_tvalid & cw.accept;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign do_emit    = cw.emit & out_free;
   assign number_ext = 64'(req_tdata);
   assign count_m1   = count_ff - 1'b1;
   assign stack_room = (count_ff < CW'(STACK_DEPTH));
   assign ram_wr_en  = cw.push & stack_room;

   // pop step reads the new top; during emit the address holds on it
   assign ram_rd_addr = cw.pop ? count_m1[AW-1:0] : count_ff[AW-1:0];

   // restoring division, one quotient bit per cycle
   assign trial    = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign trial_ge = (trial >= base_ff);

   always_comb begin
      unique case (cw.cond)
         rdc_pkg::COND_NEVER:    jump = 1'b0;
         rdc_pkg::COND_ALWAYS:   jump = 1'b1;
         rdc_pkg::COND_NO_REQ:   jump = ~req_tvalid;
         rdc_pkg::COND_BIT_LEFT: jump = (bitcnt_ff != '0);
         rdc_pkg::COND_QUOT_NZ:  jump = (quot_ff != '0);
         rdc_pkg::COND_OUT_BUSY: jump = ~out_free;
         rdc_pkg::COND_COUNT_NZ: jump = (count_ff != '0);
         default:                jump = 1'b1;
      endcase
      pc_in = jump ? cw.target : pc_ff + 1'b1;
   end

   always_comb begin
      radix_in     = radix_ff;
      base_in      = base_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bitcnt_in    = bitcnt_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end
      if (accept) begin
         if (radix_ff < rdc_pkg::RADIX_MIN) begin
            base_in = rdc_pkg::RADIX_MIN;
         end else if (radix_ff > rdc_pkg::RADIX_MAX) begin
            base_in = rdc_pkg::RADIX_MAX;
         end else begin
            base_in = radix_ff;
         end
         quot_in  = number_ext[VALUE_WIDTH-1:0];
         count_in = '0;
      end
      if (cw.div_init) begin
         rem_in    = '0;
         bitcnt_in = BW'(VALUE_WIDTH - 1);
      end
      if (cw.div_step) begin
         rem_in    = trial_ge ? DW'(trial - base_ff) : trial[DW-1:0];
         quot_in   = {quot_ff[VALUE_WIDTH-2:0], trial_ge};
         bitcnt_in = bitcnt_ff - 1'b1;
      end
      if (ram_wr_en) begin
         count_in = count_ff + 1'b1;
      end
      if (cw.pop) begin
         count_in = count_m1;
      end
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_digit_in = ram_rd_data;
         rsp_last_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rdc_pkg::PC_IDLE;
         radix_ff     <= rdc_pkg::RADIX_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bitcnt_ff    <= bitcnt_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   rdc_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rem_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_digit_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module rdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // reset leaves the block idle with an empty output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("not idle after reset");

   // one transaction at a time: input closes right after a transaction
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");

   // digits are only produced while the converter is busy
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("digit produced while idle");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (.*);
